// ===== design/bfa_pkg.sv =====
`default_nettype none
package bfa_pkg;
	localparam int MaxSegments = 16;
	localparam int BlockBytes = 64;
	localparam int HeaderBytes = 16;
	localparam int IdxW = $clog2(MaxSegments);
	localparam int CntW = $clog2(MaxSegments + 1);
	localparam int StartW = 20;
	localparam int LenW = 21;
	localparam int BlkShift = $clog2(BlockBytes);
	localparam logic [LenW-1:0] HeapBlocksMax = 21'd1048576;
	localparam logic [31:0] HeapBaseReset = 32'h8000_0000;
	localparam logic [LenW-1:0] HeapBlocksReset = 21'd4096;

	localparam logic CfgHeapBase = 1'b0;
	localparam logic CfgHeapBlocks = 1'b1;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_NULL = 3'd1,
		ST_OUT = 3'd2,
		ST_PAST_END = 3'd3,
		ST_NO_FIT = 3'd4,
		ST_FULL = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_DECIDE,
		S_SHIFT_DN,
		S_SHIFT_UP,
		S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_INIT,
		OP_LOAD,
		OP_CHECK,
		OP_SCAN,
		OP_APPLY,
		OP_SHIFT_DN,
		OP_SHIFT_UP,
		OP_PUT
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic early;       // result settled at load or check
		logic scan_end;
		logic need_dn;     // remove entry
		logic need_up;     // insert entry
		logic shift_end;
	} stat_t;
endpackage
`default_nettype wire

// ===== design/bfa_datapath.sv =====
`default_nettype none
module bfa_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire bfa_pkg::cmd_t cmd,
	output bfa_pkg::stat_t st,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_type,
	input wire logic [26:0] in_bytes,
	input wire logic [31:0] in_addr,
	input wire logic [31:0] in_hdr,
	output logic [31:0] res_addr,
	output logic [2:0] res_status
);
	localparam int IW = bfa_pkg::IdxW;
	localparam int CW = bfa_pkg::CntW;
	localparam int LW = bfa_pkg::LenW;
	localparam int SW = bfa_pkg::StartW;
	localparam int N = bfa_pkg::MaxSegments;

	logic [SW-1:0] start_q [N];
	logic [LW-1:0] len_q [N];
	logic [CW-1:0] count_q;
	logic [31:0] base_q;
	logic [LW-1:0] blocks_q;

	logic type_q;
	logic [21:0] need_q;
	logic [32:0] blk_q;        // wide enough for off/BlockBytes
	logic [33:0] end_q;
	logic [31:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] pos_q;      // best index or insertion point
	logic found_q;
	logic pdone_q;
	logic early_q;
	logic [2:0] status_q;
	logic [31:0] addr_q;
	logic dn_q, up_q;

	logic [IW-1:0] ii;
	logic [IW-1:0] pp;
	logic [IW-1:0] pm;
	logic [LW-1:0] clipped;
	logic [32:0] lo;
	logic [32:0] off;
	logic [27:0] bsum;
	logic [21:0] need_c;
	logic scan_end;
	logic [33:0] prev_end;
	logic prev_join, next_join;
	logic has_prev, has_next;
	logic clash;

	assign ii = i_q[IW-1:0];
	assign pp = pos_q[IW-1:0];
	assign pm = IW'(pos_q - CW'(1));
	assign clipped = (cfg_data[LW-1:0] > bfa_pkg::HeapBlocksMax) ?
		bfa_pkg::HeapBlocksMax : cfg_data[LW-1:0];
	assign lo = {1'b0, base_q} + 33'(bfa_pkg::HeaderBytes);
	assign off = {1'b0, in_addr} - lo;
	assign bsum = 28'(in_bytes) + 28'(bfa_pkg::HeaderBytes + bfa_pkg::BlockBytes - 1);
	assign need_c = (bsum[27:bfa_pkg::BlkShift] == '0) ? 22'd1 :
		22'(bsum[27:bfa_pkg::BlkShift]);
	assign scan_end = (i_q >= count_q);
	assign has_prev = (pos_q != '0);
	assign has_next = (pos_q < count_q);
	assign prev_end = 34'(start_q[pm]) + 34'(len_q[pm]);
	assign prev_join = has_prev && (prev_end == 34'(blk_q));
	assign next_join = has_next && (34'(start_q[pp]) == end_q);
	// freed range overlaps a free neighbour
	assign clash = (has_prev && prev_end > 34'(blk_q)) ||
		(has_next && 34'(start_q[pp]) < end_q);

	always_comb begin
		st.is_free = type_q;
		st.early = early_q;
		st.scan_end = scan_end || (type_q && pdone_q);
		st.need_dn = dn_q;
		st.need_up = up_q;
		st.shift_end = dn_q ? (i_q + CW'(1) >= count_q) : (i_q <= pos_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= bfa_pkg::HeapBaseReset;
			blocks_q <= bfa_pkg::HeapBlocksReset;
			count_q <= CW'(1);
			start_q[0] <= '0;
			len_q[0] <= bfa_pkg::HeapBlocksReset;
		end else if (cfg_we) begin
			if (cfg_index == bfa_pkg::CfgHeapBase) begin
				base_q <= cfg_data;
				count_q <= (blocks_q == '0) ? '0 : CW'(1);
				len_q[0] <= blocks_q;
			end else begin
				blocks_q <= clipped;
				count_q <= (clipped == '0) ? '0 : CW'(1);
				len_q[0] <= clipped;
			end
			start_q[0] <= '0;
		end else begin
			case (cmd.op)
				bfa_pkg::OP_APPLY: begin
					if (!type_q) begin
						if (found_q) begin
							start_q[pp] <= SW'(34'(start_q[pp]) + 34'(need_q));
							len_q[pp] <= LW'(34'(len_q[pp]) - 34'(need_q));
						end
					end else if (!clash && prev_join && next_join) begin
						len_q[pm] <= LW'(34'(len_q[pm]) + 34'(cnt_q) + 34'(len_q[pp]));
					end else if (!clash && prev_join) begin
						len_q[pm] <= LW'(34'(len_q[pm]) + 34'(cnt_q));
					end else if (!clash && next_join) begin
						start_q[pp] <= SW'(blk_q);
						len_q[pp] <= LW'(34'(len_q[pp]) + 34'(cnt_q));
					end
				end
				bfa_pkg::OP_SHIFT_DN: begin
					if (i_q + CW'(1) < count_q) begin
						start_q[ii] <= start_q[IW'(i_q + CW'(1))];
						len_q[ii] <= len_q[IW'(i_q + CW'(1))];
					end else begin
						count_q <= count_q - CW'(1);
					end
				end
				bfa_pkg::OP_SHIFT_UP: begin
					if (i_q > pos_q) begin
						start_q[ii] <= start_q[IW'(i_q - CW'(1))];
						len_q[ii] <= len_q[IW'(i_q - CW'(1))];
					end else begin
						start_q[pp] <= SW'(blk_q);
						len_q[pp] <= LW'(cnt_q);
						count_q <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bfa_pkg::OP_LOAD: begin
				type_q <= in_type;
				need_q <= need_c;
				cnt_q <= in_hdr;
				i_q <= '0;
				pos_q <= '0;
				found_q <= 1'b0;
				pdone_q <= 1'b0;
				dn_q <= 1'b0;
				up_q <= 1'b0;
				addr_q <= '0;
				early_q <= 1'b0;
				status_q <= bfa_pkg::ST_OK;
				blk_q <= {{bfa_pkg::BlkShift{1'b0}}, off[32:bfa_pkg::BlkShift]};
				// flag bad pointer now; ranges settled next cycle
				if (in_type) begin
					if (in_addr == '0) begin
						early_q <= 1'b1;
						status_q <= bfa_pkg::ST_NULL;
					end else if ({1'b0, in_addr} < lo ||
						off[bfa_pkg::BlkShift-1:0] != '0) begin
						early_q <= 1'b1;
						status_q <= bfa_pkg::ST_OUT;
					end
				end
			end
			bfa_pkg::OP_CHECK: begin
				end_q <= 34'(blk_q) + 34'(cnt_q);
				if (type_q && !early_q) begin
					if (blk_q >= 33'(blocks_q)) begin
						early_q <= 1'b1;
						status_q <= bfa_pkg::ST_OUT;
					end else if (34'(blk_q) + 34'(cnt_q) > 34'(blocks_q)) begin
						early_q <= 1'b1;
						status_q <= bfa_pkg::ST_PAST_END;
					end else if (cnt_q == '0) begin
						early_q <= 1'b1;
					end
				end
			end
			bfa_pkg::OP_SCAN: begin
				i_q <= i_q + CW'(1);
				if (!type_q) begin
					if (22'(len_q[ii]) >= need_q &&
						(!found_q || len_q[ii] < len_q[pp])) begin
						pos_q <= i_q;
						found_q <= 1'b1;
					end
				end else if (33'(start_q[ii]) < blk_q) begin
					pos_q <= i_q + CW'(1);
				end else begin
					pdone_q <= 1'b1;
				end
			end
			bfa_pkg::OP_APPLY: begin
				if (!type_q) begin
					if (!found_q) begin
						status_q <= bfa_pkg::ST_NO_FIT;
					end else begin
						addr_q <= base_q + {start_q[pp], {bfa_pkg::BlkShift{1'b0}}}
							+ 32'(bfa_pkg::HeaderBytes);
						dn_q <= (22'(len_q[pp]) == need_q);
						i_q <= pos_q;
					end
				end else if (clash) begin
					status_q <= bfa_pkg::ST_OUT;
				end else if (prev_join && next_join) begin
					dn_q <= 1'b1;
					i_q <= pos_q;
				end else if (!prev_join && !next_join) begin
					if (count_q >= CW'(N)) begin
						status_q <= bfa_pkg::ST_FULL;
					end else begin
						up_q <= 1'b1;
						i_q <= count_q;
					end
				end
			end
			bfa_pkg::OP_SHIFT_DN: i_q <= i_q + CW'(1);
			bfa_pkg::OP_SHIFT_UP: i_q <= i_q - CW'(1);
			bfa_pkg::OP_PUT: begin
				res_addr <= addr_q;
				res_status <= status_q;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/bfa_ctrl.sv =====
`default_nettype none
module bfa_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output bfa_pkg::cmd_t cmd,
	input wire bfa_pkg::stat_t st
);
	bfa_pkg::state_t state_q, state_d;
	logic ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfa_pkg::S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;

	always_comb begin
		state_d = state_q;
		ov_d = ov_q && !out_ready;
		cmd.op = bfa_pkg::OP_NONE;
		in_ready = 1'b0;
		case (state_q)
			bfa_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op = bfa_pkg::OP_LOAD;
					state_d = bfa_pkg::S_CHECK;
				end
			end
			bfa_pkg::S_CHECK: begin
				cmd.op = bfa_pkg::OP_CHECK;
				state_d = bfa_pkg::S_SCAN;
			end
			bfa_pkg::S_SCAN: begin
				if (st.early) begin
					state_d = bfa_pkg::S_DONE;
				end else if (st.scan_end) begin
					state_d = bfa_pkg::S_DECIDE;
				end else begin
					cmd.op = bfa_pkg::OP_SCAN;
				end
			end
			bfa_pkg::S_DECIDE: begin
				cmd.op = bfa_pkg::OP_APPLY;
				state_d = bfa_pkg::S_SHIFT_DN;
			end
			bfa_pkg::S_SHIFT_DN: begin
				if (st.need_up) begin
					state_d = bfa_pkg::S_SHIFT_UP;
				end else if (!st.need_dn) begin
					state_d = bfa_pkg::S_DONE;
				end else begin
					cmd.op = bfa_pkg::OP_SHIFT_DN;
					if (st.shift_end) state_d = bfa_pkg::S_DONE;
				end
			end
			bfa_pkg::S_SHIFT_UP: begin
				cmd.op = bfa_pkg::OP_SHIFT_UP;
				if (st.shift_end) state_d = bfa_pkg::S_DONE;
			end
			bfa_pkg::S_DONE: begin
				// hold until output register is free
				if (!ov_q || out_ready) begin
					cmd.op = bfa_pkg::OP_PUT;
					ov_d = 1'b1;
					state_d = bfa_pkg::S_IDLE;
				end
			end
			default: state_d = bfa_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/best_fit_block_allocator.sv =====
`default_nettype none
// Best-fit heap allocator over a sorted table of up to 16 free segments of
// 64-byte blocks. One request at a time: after acceptance it loads the
// request and checks the pointer, scans the table one entry a cycle, applies
// the result and shifts entries when an allocation empties a segment, a free
// inserts a new one or a free merges two; a rejected pointer skips the scan.
// The next item can be accepted in the cycle after the result is loaded. The
// result sits in an output register so the next item is taken while it
// waits. Configure only while idle; a write resets the table to one segment
// spanning the heap, or to none for a heap of zero blocks.
module best_fit_block_allocator (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [31:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic req_type,
	input wire logic [26:0] req_bytes,
	input wire logic [31:0] free_addr,
	input wire logic [31:0] header_blocks,
	output logic out_valid,
	input wire logic out_ready,
	output logic [31:0] result_addr,
	output logic [2:0] status
);
	bfa_pkg::cmd_t cmd;
	bfa_pkg::stat_t st;

	assign cfg_ready = 1'b1;

	bfa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .st(st)
	);

	bfa_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .st(st),
		.cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_type(req_type), .in_bytes(req_bytes),
		.in_addr(free_addr), .in_hdr(header_blocks),
		.res_addr(result_addr), .res_status(status)
	);
endmodule
`default_nettype wire
